// File: src/uqpe_pkg.sv
// uqpe_pkg: shared types, constants and helper functions of the utf-16 query encoder
// no dependencies; imported by uqpe_front, uqpe_queue, uqpe_back and the top level
package uqpe_pkg;

    localparam logic [15:0] MAX_LENGTH_RESET = 16'd1500;

    // register index decoded from the configuration address
    localparam logic REG_MAX_LENGTH = 1'b0;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [20:0] SPACE_CP       = 21'h000020;

    localparam logic [6:0] PERCENT_CHAR = 7'h25;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0][6:0] HEX_DIGITS = {
        7'h46, 7'h45, 7'h44, 7'h43, 7'h42, 7'h41, 7'h39, 7'h38,
        7'h37, 7'h36, 7'h35, 7'h34, 7'h33, 7'h32, 7'h31, 7'h30
    };

    // one code point to encode, or an empty end marker
    typedef struct packed {
        logic        mark;
        logic        last;
        logic [20:0] cp;
    } uqpe_entry_t;

    typedef struct packed {
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } uqpe_utf8_t;

    function automatic logic is_blank(input logic [15:0] cu);
        return cu inside {[16'h0009:16'h000D], 16'h0020, 16'h0085, 16'h00A0, 16'h1680,
                          [16'h2000:16'h200A], 16'h2028, 16'h2029, 16'h202F,
                          16'h205F, 16'h3000};
    endfunction

    function automatic logic keeps_byte(input logic [7:0] b);
        return b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                         8'h2D, 8'h2E, 8'h5F, 8'h7E};
    endfunction

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        return HEX_DIGITS[nib];
    endfunction

    function automatic uqpe_utf8_t utf8_encode(input logic [20:0] cp);
        uqpe_utf8_t r;
        r = '0;
        if (cp < 21'h80) begin
            r.bytes[0] = cp[7:0];
            r.last_idx = 2'd0;
        end else if (cp < 21'h800) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.last_idx = 2'd1;
        end else if (cp < 21'h10000) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.last_idx = 2'd2;
        end else begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.last_idx = 2'd3;
        end
        return r;
    endfunction

endpackage

// File: src/uqpe_front.sv
// uqpe_front: whitespace folding, length limit and surrogate joining
// depends on uqpe_pkg; emits code point entries toward the queue
module uqpe_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [15:0]           code_unit,
    input  logic                  end_of_query,
    input  logic [15:0]           max_length,
    output logic                  push_valid,
    output uqpe_pkg::uqpe_entry_t push_entry,
    input  logic                  q_full
);
    import uqpe_pkg::*;

    logic        after_space_reg, after_space_next;
    logic        space_pending_reg, space_pending_next;
    logic        high_held_reg, high_held_next;
    logic [9:0]  held_high_reg, held_high_next;
    logic [15:0] units_kept_reg, units_kept_next;

    uqpe_entry_t pend_reg [2];
    uqpe_entry_t pend_next [2];
    logic [1:0]  pend_cnt_reg, pend_cnt_next;

    logic [3:0]  slot_v;
    logic [20:0] slot_cp [4];
    logic [20:0] unit_cp;
    uqpe_entry_t new_list [2];
    logic [2:0]  new_cnt;
    logic        accept;

    assign push_valid = (pend_cnt_reg != 2'd0) && !q_full;
    assign push_entry = pend_reg[0];
    assign in_stall   = (pend_cnt_reg > 2'd1) || ((pend_cnt_reg == 2'd1) && q_full);
    assign accept     = in_valid && !in_stall;

    // state update of one code unit
    always_comb
    begin
        after_space_next   = after_space_reg;
        space_pending_next = space_pending_reg;
        high_held_next     = high_held_reg;
        held_high_next     = held_high_reg;
        units_kept_next    = units_kept_reg;
        slot_v             = '0;
        unit_cp            = '0;
        if (is_blank(code_unit))
        begin
            slot_v[0]      = high_held_reg;
            high_held_next = 1'b0;
            held_high_next = '0;
            if (!after_space_reg)
            begin
                space_pending_next = 1'b1;
                after_space_next   = 1'b1;
            end
        end
        else
        begin
            after_space_next = 1'b0;
            if (space_pending_reg)
            begin
                space_pending_next = 1'b0;
                if (units_kept_next < max_length)
                begin
                    units_kept_next = units_kept_next + 16'd1;
                    slot_v[0]       = high_held_next;
                    high_held_next  = 1'b0;
                    held_high_next  = '0;
                    slot_v[1]       = 1'b1;
                end
            end
            if (units_kept_next < max_length)
            begin
                units_kept_next = units_kept_next + 16'd1;
                if (code_unit inside {[16'hD800:16'hDBFF]})
                begin
                    slot_v[0]      = slot_v[0] | high_held_next;
                    held_high_next = code_unit[9:0];
                    high_held_next = 1'b1;
                end
                else if (code_unit inside {[16'hDC00:16'hDFFF]})
                begin
                    if (high_held_next)
                    begin
                        unit_cp = 21'h10000 + {1'b0, held_high_next, code_unit[9:0]};
                    end
                    else
                    begin
                        unit_cp = REPLACEMENT_CP;
                    end
                    high_held_next = 1'b0;
                    held_high_next = '0;
                    slot_v[2]      = 1'b1;
                end
                else
                begin
                    slot_v[0]      = slot_v[0] | high_held_next;
                    high_held_next = 1'b0;
                    held_high_next = '0;
                    unit_cp        = {5'd0, code_unit};
                    slot_v[2]      = 1'b1;
                end
            end
        end
        if (end_of_query)
        begin
            slot_v[3]          = high_held_next;
            after_space_next   = 1'b1;
            space_pending_next = 1'b0;
            high_held_next     = 1'b0;
            held_high_next     = '0;
            units_kept_next    = '0;
        end
    end

    // compact the slots into at most two entries, in order
    always_comb
    begin
        slot_cp[0]  = REPLACEMENT_CP;
        slot_cp[1]  = SPACE_CP;
        slot_cp[2]  = unit_cp;
        slot_cp[3]  = REPLACEMENT_CP;
        new_list[0] = '0;
        new_list[1] = '0;
        new_cnt     = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (slot_v[k] && (new_cnt < 3'd2))
            begin
                new_list[new_cnt[0]].cp = slot_cp[k];
                new_cnt = new_cnt + 3'd1;
            end
        end
        if (end_of_query)
        begin
            if (new_cnt == 3'd0)
            begin
                new_list[0].mark = 1'b1;
                new_list[0].last = 1'b1;
                new_cnt          = 3'd1;
            end
            else if (new_cnt == 3'd1)
            begin
                new_list[0].last = 1'b1;
            end
            else
            begin
                new_list[1].last = 1'b1;
            end
        end
    end

    always_comb
    begin
        pend_next[0]  = pend_reg[0];
        pend_next[1]  = pend_reg[1];
        pend_cnt_next = pend_cnt_reg;
        if (accept)
        begin
            pend_next[0]  = new_list[0];
            pend_next[1]  = new_list[1];
            pend_cnt_next = new_cnt[1:0];
        end
        else if (push_valid)
        begin
            pend_next[0]  = pend_reg[1];
            pend_cnt_next = pend_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_space_reg   <= 1'b1;
            space_pending_reg <= 1'b0;
            high_held_reg     <= 1'b0;
            held_high_reg     <= '0;
            units_kept_reg    <= '0;
            pend_cnt_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                after_space_reg   <= after_space_next;
                space_pending_reg <= space_pending_next;
                high_held_reg     <= high_held_next;
                held_high_reg     <= held_high_next;
                units_kept_reg    <= units_kept_next;
            end
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg[0] <= pend_next[0];
        pend_reg[1] <= pend_next[1];
    end

endmodule

// File: src/uqpe_queue.sv
// uqpe_queue: small entry queue between front and back
// depends on uqpe_pkg for the entry type and depth
module uqpe_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  uqpe_pkg::uqpe_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output uqpe_pkg::uqpe_entry_t pop_entry,
    output logic                  not_empty
);
    import uqpe_pkg::*;

    uqpe_entry_t           mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: src/uqpe_back.sv
// uqpe_back: utf-8 expansion and percent escaping, one character per cycle while out_stall is low
// depends on uqpe_pkg; drains the queue and drives the output register
module uqpe_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  uqpe_pkg::uqpe_entry_t q_entry,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [6:0]            out_char,
    output logic                  char_valid,
    output logic                  last_of_query
);
    import uqpe_pkg::*;

    logic            busy_reg;
    logic [3:0][7:0] bytes_reg;
    logic [1:0]      last_idx_reg;
    logic [1:0]      byte_idx_reg;
    logic [1:0]      phase_reg;
    logic            mark_reg;
    logic            last_reg;

    logic            out_valid_reg;
    logic [6:0]      out_char_reg;
    logic            char_valid_reg;
    logic            last_of_query_reg;

    logic [7:0]      cur_byte;
    logic            keep;
    logic            byte_done;
    logic            entry_done;
    logic            out_load;
    logic            emit;
    logic [6:0]      ch;
    uqpe_utf8_t      enc;

    assign cur_byte   = bytes_reg[byte_idx_reg];
    assign keep       = keeps_byte(cur_byte);
    assign byte_done  = mark_reg || keep || (phase_reg == 2'd2);
    assign entry_done = mark_reg || (byte_done && (byte_idx_reg == last_idx_reg));
    assign out_load   = !out_valid_reg || !out_stall;
    assign emit       = busy_reg && out_load;
    assign q_pop      = q_valid && (!busy_reg || (emit && entry_done));
    assign enc        = utf8_encode(q_entry.cp);

    always_comb
    begin
        if (mark_reg)
        begin
            ch = '0;
        end
        else if (keep)
        begin
            ch = cur_byte[6:0];
        end
        else
        begin
            case (phase_reg)
                2'd0:    ch = PERCENT_CHAR;
                2'd1:    ch = hex_char(cur_byte[7:4]);
                default: ch = hex_char(cur_byte[3:0]);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            byte_idx_reg  <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg     <= 1'b1;
                byte_idx_reg <= '0;
                phase_reg    <= '0;
            end
            else if (emit)
            begin
                if (entry_done)
                begin
                    busy_reg <= 1'b0;
                end
                else if (byte_done)
                begin
                    byte_idx_reg <= byte_idx_reg + 2'd1;
                    phase_reg    <= '0;
                end
                else
                begin
                    phase_reg <= phase_reg + 2'd1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            bytes_reg    <= enc.bytes;
            last_idx_reg <= enc.last_idx;
            mark_reg     <= q_entry.mark;
            last_reg     <= q_entry.last;
        end
        if (emit)
        begin
            out_char_reg      <= ch;
            char_valid_reg    <= !mark_reg;
            last_of_query_reg <= last_reg && entry_done;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_char      = out_char_reg;
    assign char_valid    = char_valid_reg;
    assign last_of_query = last_of_query_reg;

endmodule

// File: src/utf16_query_percent_encoder.sv
// utf16_query_percent_encoder: top level, configuration register and part wiring
// depends on uqpe_pkg, uqpe_front, uqpe_queue and uqpe_back
//
// Takes one utf-16 code unit per item and gives the percent-encoded utf-8
// text of the query, one ascii character per result item. Whitespace at
// both ends of a query is dropped and inner runs fold to one space, at most
// max_length normalized units are kept, surrogate pairs are joined and a
// lone surrogate turns into U+FFFD. The final result of a query carries
// last_of_query; a query that yields no character gives one empty marker
// (char_valid low, out_char zero). The front takes an item every cycle as
// long as that item yields at most one code point and the four-entry queue
// has room; an item yielding two code points stalls the input until the
// queue has taken the first of them. The back sends one character per
// cycle while out_stall is low, so a code point gives 1 to 12 characters
// (one or three for each of its 1 to 4 utf-8 bytes) and the sustained rate
// is set by this character sequencer. There is no clearing pass after
// reset. max_length sits at byte address 0 of the configuration port and
// resets to 1500; the user must write it only while idle, and the block
// itself does not enforce this.
module utf16_query_percent_encoder (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_unit,
    input  logic        end_of_query,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  out_char,
    output logic        char_valid,
    output logic        last_of_query
);
    import uqpe_pkg::*;

    logic [15:0] max_length_reg;
    logic        cfg_write;

    logic        push_valid;
    uqpe_entry_t push_entry;
    logic        q_full;
    logic        q_pop;
    uqpe_entry_t q_entry;
    logic        q_valid;

    // apb: zero wait states, register index in the word address
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_MAX_LENGTH) ? {16'd0, max_length_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_MAX_LENGTH))
        begin
            max_length_reg <= pwdata[15:0];
        end
    end

    // front: classifies units and queues code points
    uqpe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .code_unit    (code_unit),
        .end_of_query (end_of_query),
        .max_length   (max_length_reg),
        .push_valid   (push_valid),
        .push_entry   (push_entry),
        .q_full       (q_full)
    );

    // decouples the two sides so each can stall on its own
    uqpe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_entry),
        .not_empty  (q_valid)
    );

    // back: expands each code point into escaped characters
    uqpe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_char      (out_char),
        .char_valid    (char_valid),
        .last_of_query (last_of_query)
    );

endmodule

// File: src/uqpe_checker.sv
// uqpe_checker: port-level assertions for the query encoder
// depends on nothing; bound to utf16_query_percent_encoder below
module uqpe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       end_of_query,
    input logic       out_valid,
    input logic       out_stall,
    input logic [6:0] out_char,
    input logic       char_valid,
    input logic       last_of_query
);

    logic [7:0] open_queries_reg;
    logic       seen_input_reg;
    logic       in_end;
    logic       out_end;

    assign in_end  = in_valid && !in_stall && end_of_query;
    assign out_end = out_valid && !out_stall && last_of_query;

    // queries accepted but not yet closed on the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_queries_reg <= '0;
            seen_input_reg   <= 1'b0;
        end
        else
        begin
            if (in_end && !out_end)
            begin
                open_queries_reg <= open_queries_reg + 8'd1;
            end
            else if (out_end && !in_end)
            begin
                open_queries_reg <= open_queries_reg - 8'd1;
            end
            if (in_valid && !in_stall)
            begin
                seen_input_reg <= 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(char_valid)
            && $stable(last_of_query))
        else $error("result item changed while stalled");

    a_end_matches_query: assert property (@(posedge clk) disable iff (!rst_n)
        out_end |-> open_queries_reg != 8'd0)
        else $error("query end sent with no query end taken");

    a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_input_reg)
        else $error("result item before any input item");

    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_valid |-> last_of_query && out_char == 7'd0)
        else $error("empty marker is not a zero final item");

endmodule

bind utf16_query_percent_encoder uqpe_checker u_uqpe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .end_of_query  (end_of_query),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .char_valid    (char_valid),
    .last_of_query (last_of_query)
);
